FILE: hw/rtl/b16ar_pkg.sv
// ----------------------------------------------------------------------------
// b16ar_pkg
// Shared types, operation codes and helpers for the binary16 arithmetic unit.
// ----------------------------------------------------------------------------
package b16ar_pkg;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  localparam logic [15:0] QNAN_BITS    = 16'h7E00;
  localparam logic [15:0] POS_INF_BITS = 16'h7C00;
  localparam logic [15:0] NEG_MAX_BITS = 16'hFBFF;

  // quotient bits produced by the divider: floor(na * 2^12 / nb)
  localparam int unsigned DIV_STEPS = 13;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transfer
    logic setup;      // decode, specials, add/mul, divider init
    logic div_step;   // one restoring division step
    logic norm_step;  // one leading-one scan step
    logic rnd;        // align to result grid
    logic emit;       // write output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic spec;       // result fixed by special-case rules
    logic is_div;
    logic norm_done;
  } stat_t;

  // leading zeros of an 11-bit significand (input nonzero)
  function automatic logic [3:0] lz11(input logic [10:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (v[i]) n = 4'(10 - i);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/binary16_arith_round_up_unit.sv
// ----------------------------------------------------------------------------
// binary16_arith_round_up_unit
// IEEE binary16 add/sub/mul/div, rounded toward plus infinity.
// ----------------------------------------------------------------------------
// One item at a time. After an input transfer the unit decodes operands and
// resolves special cases (NaN in, invalid ops, infinities, zeros) in a setup
// step; add/sub align with a sticky bit and mul uses one 11x11 multiply in that
// same step. Divide then runs a restoring divider, one quotient bit per cycle,
// 13 quotient bits in all. A leading-one scan (8 bits or 1 bit per cycle) and an
// align step follow, then a round/pack step; special cases go straight to pack.
// An output stall holds the unit in its pack step until the output register
// frees up. The result sits in an output register, so a new input transfer is
// taken while a result waits.
// Overflow gives +inf for positive and 0xFBFF for negative results; every NaN
// comes out as 0x7E00; an exactly cancelling sum gives +0.
// ----------------------------------------------------------------------------
module binary16_arith_round_up_unit import b16ar_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_result
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: handshakes and command issue
  b16ar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic datapath and output register
  b16ar_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .stat         (stat),
    .in_func      (in_func),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_result   (out_result)
  );

  // busy after every input transfer
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("unit not busy after input transfer");

  // output register only written when free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwritten while held");

  // at most one datapath operation per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.setup, cmd.div_step, cmd.norm_step, cmd.rnd, cmd.emit}))
    else $error("conflicting datapath commands");

  // NaN results are always canonical
  a_qnan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result[14:10] != 5'd31) || (out_result[9:0] == 10'd0)
                  || (out_result == QNAN_BITS))
    else $error("non-canonical NaN");

endmodule

FILE: hw/rtl/b16ar_ctrl.sv
// ----------------------------------------------------------------------------
// b16ar_ctrl
// Sequencer for the binary16 unit: issues datapath commands, owns handshakes.
// ----------------------------------------------------------------------------
module b16ar_ctrl import b16ar_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_NORM  = 3'd3;
  localparam logic [2:0] ST_RND   = 3'd4;
  localparam logic [2:0] ST_PACK  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       ovld_r, ovld_nxt;
  logic       out_free;

  assign out_free = !ovld_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    ovld_nxt  = ovld_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        cnt_nxt   = 4'd0;
        priority if (stat.spec) state_nxt = ST_PACK;
        else if (stat.is_div)   state_nxt = ST_DIV;
        else                    state_nxt = ST_NORM;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == 4'(DIV_STEPS - 1)) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (stat.norm_done) state_nxt = ST_RND;
        else cmd.norm_step = 1'b1;
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_PACK;
      end
      ST_PACK: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          ovld_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 4'd0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

FILE: hw/rtl/b16ar_dp.sv
// ----------------------------------------------------------------------------
// b16ar_dp
// Datapath: operand decode, add/mul/div, leading-one scan, round-up, packing.
// ----------------------------------------------------------------------------
module b16ar_dp import b16ar_pkg::*; (
  input  logic        clk,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  output logic [15:0] out_result
);

  logic [1:0]  func_r;
  logic [15:0] opa_r, opb_r;

  // working value: m_r * 2^e_r plus a fraction flagged by st_r
  logic [24:0]       m_r, m_nxt;
  logic [24:0]       s_r, s_nxt;
  logic [4:0]        p_r, p_nxt;
  logic signed [7:0] e_r, e_nxt;
  logic              st_r, st_nxt;
  logic              sign_r, sign_nxt;
  logic              spec_r;
  logic [15:0]       res_r;
  logic [11:0]       r_r, r_nxt;
  logic [10:0]       nb_r;
  logic [10:0]       mm_r;
  logic signed [7:0] q_r;
  logic              inex_r, ovf_r;
  logic [15:0]       oreg_r;

  // ---------------- decode ----------------
  logic              sa, sb;
  logic [4:0]        xa, xb;
  logic [10:0]       ma, mb;
  logic signed [7:0] ea, eb;
  logic              nana, nanb, infa, infb, zera, zerb;

  assign sa = opa_r[15];
  assign sb = opb_r[15] ^ (func_r == FUNC_SUB);
  assign xa = opa_r[14:10];
  assign xb = opb_r[14:10];
  assign ma = {xa != 5'd0, opa_r[9:0]};
  assign mb = {xb != 5'd0, opb_r[9:0]};
  assign ea = (xa == 5'd0) ? -8'sd24 : $signed({3'b000, xa}) - 8'sd25;
  assign eb = (xb == 5'd0) ? -8'sd24 : $signed({3'b000, xb}) - 8'sd25;
  assign nana = (xa == 5'd31) && (opa_r[9:0] != 10'd0);
  assign nanb = (xb == 5'd31) && (opb_r[9:0] != 10'd0);
  assign infa = (xa == 5'd31) && (opa_r[9:0] == 10'd0);
  assign infb = (xb == 5'd31) && (opb_r[9:0] == 10'd0);
  assign zera = (opa_r[14:0] == 15'd0);
  assign zerb = (opb_r[14:0] == 15'd0);

  // ---------------- special cases ----------------
  logic        spec;
  logic [15:0] spec_val;
  logic        sx;
  assign sx = sa ^ sb;

  always_comb begin
    spec     = 1'b1;
    spec_val = QNAN_BITS;
    if (nana || nanb) begin
      spec_val = QNAN_BITS;
    end else begin
      unique case (func_r)
        FUNC_ADD, FUNC_SUB: begin
          priority if (infa && infb && (sa != sb)) spec_val = QNAN_BITS;
          else if (infa) spec_val = {sa, POS_INF_BITS[14:0]};
          else if (infb) spec_val = {sb, POS_INF_BITS[14:0]};
          else if (zera && zerb) spec_val = {sa & sb, 15'd0};
          else if ((sa != sb) && (opa_r[14:0] == opb_r[14:0])) spec_val = 16'd0;
          else spec = 1'b0;
        end
        FUNC_MUL: begin
          priority if ((infa && zerb) || (infb && zera)) spec_val = QNAN_BITS;
          else if (infa || infb) spec_val = {sx, POS_INF_BITS[14:0]};
          else if (zera || zerb) spec_val = {sx, 15'd0};
          else spec = 1'b0;
        end
        FUNC_DIV: begin
          priority if ((zera && zerb) || (infa && infb)) spec_val = QNAN_BITS;
          else if (zera || infb) spec_val = {sx, 15'd0};
          else if (zerb || infa) spec_val = {sx, POS_INF_BITS[14:0]};
          else spec = 1'b0;
        end
        default: spec = 1'b1;
      endcase
    end
  end

  assign stat.spec   = spec;
  assign stat.is_div = (func_r == FUNC_DIV);
  assign stat.norm_done = s_r[24] || (s_r == 25'd0);

  // ---------------- add/sub alignment with sticky ----------------
  logic              a_big;
  logic [10:0]       mbig, msml;
  logic signed [7:0] ebig, esml, dexp;
  logic [4:0]        d5;
  logic [23:0]       mb24, ms24, shr;
  logic              stk, sbig;
  logic [24:0]       sum;

  assign a_big = opa_r[14:0] >= opb_r[14:0];
  assign mbig  = a_big ? ma : mb;
  assign msml  = a_big ? mb : ma;
  assign ebig  = a_big ? ea : eb;
  assign esml  = a_big ? eb : ea;
  assign sbig  = a_big ? sa : sb;
  assign dexp  = ebig - esml;
  assign d5    = dexp[4:0];
  assign mb24  = {mbig, 13'd0};
  assign ms24  = {msml, 13'd0};
  assign shr   = ms24 >> d5;
  assign stk   = (shr << d5) != ms24;
  assign sum   = (sa == sb) ? ({1'b0, mb24} + {1'b0, shr})
                            : ({1'b0, mb24} - {1'b0, shr} - {24'd0, stk});

  // ---------------- multiply ----------------
  logic [21:0] prod;
  assign prod = ma * mb;

  // ---------------- divider init ----------------
  logic [3:0]  lza, lzb;
  logic [10:0] na, nb;
  assign lza = lz11(ma);
  assign lzb = lz11(mb);
  assign na  = ma << lza;
  assign nb  = mb << lzb;

  // ---------------- divider step ----------------
  logic        qbit;
  logic [11:0] rsub;
  assign qbit = r_r >= {1'b0, nb_r};
  assign rsub = qbit ? (r_r - {1'b0, nb_r}) : r_r;

  always_comb begin
    m_nxt    = m_r;
    s_nxt    = s_r;
    p_nxt    = p_r;
    e_nxt    = e_r;
    st_nxt   = st_r;
    sign_nxt = sign_r;
    r_nxt    = r_r;
    if (cmd.setup) begin
      p_nxt = 5'd24;
      unique case (func_r)
        FUNC_ADD, FUNC_SUB: begin
          m_nxt    = sum;
          e_nxt    = ebig - 8'sd13;
          st_nxt   = stk;
          sign_nxt = sbig;
        end
        FUNC_MUL: begin
          m_nxt    = {3'd0, prod};
          e_nxt    = ea + eb;
          st_nxt   = 1'b0;
          sign_nxt = sx;
        end
        FUNC_DIV: begin
          m_nxt    = 25'd0;
          e_nxt    = (ea - $signed({4'd0, lza})) - (eb - $signed({4'd0, lzb})) - 8'sd12;
          st_nxt   = 1'b0;
          sign_nxt = sx;
          r_nxt    = {1'b0, na};
        end
        default: m_nxt = m_r;
      endcase
      s_nxt = m_nxt;
    end else if (cmd.div_step) begin
      m_nxt  = {m_r[23:0], qbit};
      s_nxt  = m_nxt;
      r_nxt  = {rsub[10:0], 1'b0};
      st_nxt = (rsub != 12'd0);
    end else if (cmd.norm_step) begin
      if (s_r[24:17] == 8'd0) begin
        s_nxt = {s_r[16:0], 8'd0};
        p_nxt = p_r - 5'd8;
      end else begin
        s_nxt = {s_r[23:0], 1'b0};
        p_nxt = p_r - 5'd1;
      end
    end
  end

  // ---------------- align to result grid ----------------
  logic signed [7:0] big, q0, qg, sh, nsh;
  logic [24:0]       mrs, mls;
  logic [10:0]       mm;
  logic              inex, ovf;

  assign big = $signed({3'b000, p_r}) + e_r;
  assign q0  = big - 8'sd10;
  assign qg  = (q0 < -8'sd24) ? -8'sd24 : q0;
  assign sh  = qg - e_r;
  assign nsh = -sh;
  assign mrs = m_r >> sh[4:0];
  assign mls = m_r << nsh[5:0];

  always_comb begin
    mm   = 11'd0;
    inex = st_r;
    ovf  = 1'b0;
    if (m_r != 25'd0) begin
      ovf = big > 8'sd15;
      priority if (sh >= 8'sd25) begin
        mm   = 11'd0;
        inex = 1'b1;
      end else if (sh > 8'sd0) begin
        mm   = mrs[10:0];
        inex = st_r || ((mrs << sh[4:0]) != m_r);
      end else begin
        mm   = mls[10:0];
      end
    end
  end

  // ---------------- round up and pack ----------------
  logic [11:0]       m12, mfin;
  logic signed [7:0] qf, be;
  logic              povf;
  logic [15:0]       packed_val, final_val;

  assign m12  = {1'b0, mm_r} + {11'd0, (!sign_r && inex_r)};
  assign mfin = m12[11] ? 12'd1024 : m12;
  assign qf   = m12[11] ? q_r + 8'sd1 : q_r;
  assign be   = qf + 8'sd25;
  assign povf = ovf_r || (mfin[10] && (be >= 8'sd31));

  always_comb begin
    priority if (povf) packed_val = sign_r ? NEG_MAX_BITS : POS_INF_BITS;
    else if (mfin[10]) packed_val = {sign_r, be[4:0], mfin[9:0]};
    else packed_val = {sign_r, 5'd0, mfin[9:0]};
  end

  assign final_val  = spec_r ? res_r : packed_val;
  assign out_result = oreg_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      opa_r  <= in_operand_a;
      opb_r  <= in_operand_b;
    end
    if (cmd.setup) begin
      spec_r <= spec;
      res_r  <= spec_val;
      nb_r   <= nb;
    end
    m_r    <= m_nxt;
    s_r    <= s_nxt;
    p_r    <= p_nxt;
    e_r    <= e_nxt;
    st_r   <= st_nxt;
    sign_r <= sign_nxt;
    r_r    <= r_nxt;
    if (cmd.rnd) begin
      mm_r   <= mm;
      q_r    <= qg;
      inex_r <= inex;
      ovf_r  <= ovf;
    end
    if (cmd.emit) oreg_r <= final_val;
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary16 add/sub/mul/div unit (round up).
// A directed set of edge operands is followed by random operand pairs. Each
// input transfer is predicted by a behavioral model inside the bench; every
// result transfer is compared against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import b16ar_pkg::*;

  // scoreboard: predicts the rounded result of each operation, in order
  class arith_scoreboard;
    logic [15:0] pending_q[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // round sign * (mant * 2^ex + sticky) toward plus infinity
    function automatic logic [15:0] pack_up(logic sgn, logic [63:0] mant, int ex,
                                            bit sticky);
      int msb, top, q, sh, be;
      bit inexact;
      msb = 63;
      inexact = sticky;
      if (mant == 0) return {sgn, 14'd0, (!sgn && sticky)};
      while (!mant[msb]) msb--;
      top = msb + ex;
      if (top > 15) return sgn ? NEG_MAX_BITS : POS_INF_BITS;
      q = top - 10;
      if (q < -24) q = -24;
      sh = q - ex;
      if (sh >= 64) begin
        inexact = 1;
        mant = 0;
      end else if (sh > 0) begin
        if ((mant & ((64'd1 << sh) - 1)) != 0) inexact = 1;
        mant = mant >> sh;
      end else if (sh < 0) begin
        mant = mant << (-sh);
      end
      if (!sgn && inexact) mant++;
      if (mant == 2048) begin
        mant = 1024;
        q++;
      end
      if (mant >= 1024) begin
        be = q + 25;
        if (be >= 31) return sgn ? NEG_MAX_BITS : POS_INF_BITS;
        return {sgn, 5'(be), mant[9:0]};
      end
      return {sgn, 5'd0, mant[9:0]};
    endfunction

    function automatic logic [15:0] predict(logic [1:0] fn, logic [15:0] a,
                                            logic [15:0] b);
      logic sa, sb, s;
      logic [63:0] ma, mb, va, vb, num;
      int ea, eb, emin;
      bit nana, nanb, infa, infb, zera, zerb;
      sa = a[15];
      sb = b[15] ^ (fn == FUNC_SUB);
      ma = (a[14:10] == 0) ? {54'd0, a[9:0]} : {53'd0, 1'b1, a[9:0]};
      mb = (b[14:10] == 0) ? {54'd0, b[9:0]} : {53'd0, 1'b1, b[9:0]};
      ea = (a[14:10] == 0) ? -24 : int'(a[14:10]) - 25;
      eb = (b[14:10] == 0) ? -24 : int'(b[14:10]) - 25;
      nana = &a[14:10] && a[9:0] != 0;
      nanb = &b[14:10] && b[9:0] != 0;
      infa = &a[14:10] && !nana;
      infb = &b[14:10] && !nanb;
      zera = a[14:0] == 0;
      zerb = b[14:0] == 0;
      s = sa ^ sb;
      if (nana || nanb) return QNAN_BITS;
      if (fn == FUNC_ADD || fn == FUNC_SUB) begin
        if (infa && infb && sa != sb) return QNAN_BITS;
        if (infa) return {sa, 15'h7C00};
        if (infb) return {sb, 15'h7C00};
        if (zera && zerb) return {sa & sb, 15'd0};
        emin = ea < eb ? ea : eb;
        va = ma << (ea - emin);
        vb = mb << (eb - emin);
        if (sa == sb) return pack_up(sa, va + vb, emin, 0);
        if (va == vb) return 16'd0;
        if (va > vb) return pack_up(sa, va - vb, emin, 0);
        return pack_up(sb, vb - va, emin, 0);
      end
      if (fn == FUNC_MUL) begin
        if ((infa && zerb) || (infb && zera)) return QNAN_BITS;
        if (infa || infb) return {s, 15'h7C00};
        if (zera || zerb) return {s, 15'd0};
        return pack_up(s, ma * mb, ea + eb, 0);
      end
      if ((zera && zerb) || (infa && infb)) return QNAN_BITS;
      if (zera || infb) return {s, 15'd0};
      if (zerb || infa) return {s, 15'h7C00};
      num = ma << 40;
      return pack_up(s, num / mb, ea - eb - 40, (num % mb) != 0);
    endfunction

    function void note_input(logic [1:0] fn, logic [15:0] a, logic [15:0] b);
      pending_q.push_back(predict(fn, a, b));
    endfunction

    task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task automatic check_result(logic [15:0] got);
      logic [15:0] want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) report($sformatf("result %h, expected %h", got, want));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_func = FUNC_ADD;
  logic [15:0] in_operand_a = 0;
  logic [15:0] in_operand_b = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] out_result;

  arith_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  localparam int unsigned CYCLE_LIMIT = 400000;

  always #4 clk = ~clk;

  binary16_arith_round_up_unit i_dut (.*);

  // note input transfers and check result transfers at the same edge
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && in_valid && !in_stall) sb.note_input(in_func, in_operand_a, in_operand_b);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_result);
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall pattern: runs of free flow, light stalling and heavy stalling
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // interesting operand patterns: zeros, subnormals, extremes, inf, NaN
  logic [15:0] edge_vals[14] = '{16'h0000, 16'h8000, 16'h0001, 16'h8001, 16'h03FF,
    16'h0400, 16'h3C00, 16'hBC00, 16'h7BFF, 16'hFBFF, 16'h7C00, 16'hFC00,
    16'h7E00, 16'hFD55};

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return edge_vals[$urandom_range(0, 13)];
      1: return {1'($urandom), 5'd0, 10'($urandom)};          // subnormal
      2: return {1'($urandom), 5'd31, 10'($urandom)};         // inf / NaN
      3: return {1'($urandom), 5'($urandom_range(13, 17)), 10'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transfer; in_valid held high across back-to-back transfers
  task automatic send_item(logic [1:0] fn, logic [15:0] a, logic [15:0] b);
    in_valid     <= 1'b1;
    in_func      <= fn;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // one edge first so the monitor has noted the last input transfer
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] a;
    int burst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operation against assorted edge operands
    for (int i = 0; i < 6; i++) begin
      a = edge_vals[(i * 5) % 14];
      send_item(2'(i), a, edge_vals[(i * 3 + 7) % 14]);
    end
    send_item(FUNC_ADD, 16'h3C00, 16'hBC00);  // exact cancel gives +0
    send_item(FUNC_ADD, 16'h8000, 16'h8000);  // -0 + -0
    send_item(FUNC_SUB, 16'h7C00, 16'h7C00);  // inf - inf
    send_item(FUNC_ADD, 16'h7BFF, 16'h7BFF);  // positive overflow
    send_item(FUNC_ADD, 16'hFBFF, 16'hFBFF);  // negative overflow saturates
    send_item(FUNC_MUL, 16'h0000, 16'hFC00);  // 0 * inf
    send_item(FUNC_MUL, 16'h0001, 16'h0001);  // positive tiny rounds up
    send_item(FUNC_MUL, 16'h8001, 16'h0001);  // negative tiny truncates to -0
    send_item(FUNC_DIV, 16'h0000, 16'h0000);  // 0 / 0
    send_item(FUNC_DIV, 16'h7C00, 16'hFC00);  // inf / inf
    send_item(FUNC_DIV, 16'h3C00, 16'h8000);  // divide by zero
    send_item(FUNC_DIV, 16'h4000, 16'h7C00);  // x / inf
    send_item(FUNC_DIV, 16'h3C00, 16'h4200);  // inexact quotient, sticky
    send_item(FUNC_DIV, 16'h7BFF, 16'h0001);  // overflow through divide
    send_item(FUNC_ADD, 16'h7D01, 16'h3C00);  // signaling NaN in
    send_item(FUNC_MUL, 16'hFFFF, 16'hFFFF);
    wait_drained();  // sender holds off until all results are back

    // random: bursts of transfers with random gaps
    for (int n = 0; n < 1550; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        send_item(2'($urandom), pick_operand(), pick_operand());
        n++;
      end
      if ($urandom_range(0, 2) != 0) send_gap($urandom_range(0, 30));
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
